@@ sv/mandelbrot_escape_time_top_macros.svh @@
// Assertion macros for the checks in the escape-time top-level block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MET_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/met_pkg.sv @@
package met_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd4;

  localparam logic [15:0]        RST_MAX_ITER    = 16'd256;
  localparam logic signed [31:0] RST_ORIGIN_REAL = -32'sd744460997;
  localparam logic signed [31:0] RST_ORIGIN_IMAG = -32'sd322122547;
  localparam logic [30:0]        RST_STEP_REAL   = 31'd596523;
  localparam logic [30:0]        RST_STEP_IMAG   = 31'd596523;

  // 4.0 in Q4.28, compared against the 37-bit sum of squares.
  localparam logic signed [36:0] ESCAPE_LIMIT = 37'sd1073741824;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic coord_mul;
    logic coord_add;
    logic iter_mul;
    logic iter_upd;
    logic load_out;
  } met_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cont;
  } met_status_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/met_ctrl.sv @@
module met_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  met_pkg::met_status_t status,
  output met_pkg::met_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COORD_MUL,
    S_COORD_ADD,
    S_ITER_MUL,
    S_ITER_UPD,
    S_HOLD
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_COORD_MUL;
        end
      end
      S_COORD_MUL: begin
        cmd.coord_mul = 1'b1;
        state_next    = S_COORD_ADD;
      end
      S_COORD_ADD: begin
        cmd.coord_add = 1'b1;
        state_next    = S_ITER_MUL;
      end
      S_ITER_MUL: begin
        cmd.iter_mul = 1'b1;
        state_next   = S_ITER_UPD;
      end
      S_ITER_UPD: begin
        cmd.iter_upd = 1'b1;
        if (status.cont) begin
          state_next = S_ITER_MUL;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/met_datapath.sv @@
module met_datapath #(
  parameter int unsigned MAX_COLUMNS = 4096,
  parameter int unsigned MAX_ROWS    = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [23:0]                       s_tdata,
  output logic [15:0]                       m_tdata,
  input  met_pkg::met_cmd_t                 cmd,
  output met_pkg::met_status_t              status
);

  // Configuration registers.
  logic [15:0]        max_iter;
  logic signed [31:0] origin_real;
  logic signed [31:0] origin_imag;
  logic [30:0]        step_real;
  logic [30:0]        step_imag;

  // Pixel and coordinate registers.
  logic [11:0]        col;
  logic [11:0]        row;
  logic [11:0]        col_next;
  logic [11:0]        row_next;
  logic [42:0]        cprod_real;
  logic [42:0]        cprod_imag;
  logic signed [31:0] cr;
  logic signed [31:0] ci;

  // Iteration registers.
  logic signed [31:0] u;
  logic signed [31:0] v;
  logic [15:0]        n;
  logic signed [63:0] uu;
  logic signed [63:0] vv;
  logic signed [63:0] uv;
  logic signed [63:0] uu_next;
  logic signed [63:0] vv_next;
  logic signed [63:0] uv_next;

  logic signed [35:0] u2;
  logic signed [35:0] v2;
  logic signed [36:0] uv2;
  logic signed [36:0] mag;
  logic signed [63:0] nu_wide;
  logic signed [63:0] nv_wide;

  always_comb begin
    col_next = s_tdata[11:0];
    row_next = s_tdata[23:12];
    if (32'(s_tdata[11:0]) >= MAX_COLUMNS) begin
      col_next = 12'(MAX_COLUMNS - 1);
    end
    if (32'(s_tdata[23:12]) >= MAX_ROWS) begin
      row_next = 12'(MAX_ROWS - 1);
    end
  end

  assign uu_next = u * u;
  assign vv_next = v * v;
  assign uv_next = u * v;

  // Products shifted right by the fraction width round toward minus infinity.
  assign u2      = uu[63:28];
  assign v2      = vv[63:28];
  assign uv2     = uv[63:27];
  assign mag     = 37'(u2) + 37'(v2);
  assign nu_wide = 64'(u2) - 64'(v2) + 64'(cr);
  assign nv_wide = 64'(uv2) + 64'(ci);

  assign status.cont = (n < max_iter) && (mag < met_pkg::ESCAPE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter    <= met_pkg::RST_MAX_ITER;
      origin_real <= met_pkg::RST_ORIGIN_REAL;
      origin_imag <= met_pkg::RST_ORIGIN_IMAG;
      step_real   <= met_pkg::RST_STEP_REAL;
      step_imag   <= met_pkg::RST_STEP_IMAG;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        met_pkg::REG_MAX_ITER:    max_iter    <= cfg_data[15:0];
        met_pkg::REG_ORIGIN_REAL: origin_real <= cfg_data;
        met_pkg::REG_ORIGIN_IMAG: origin_imag <= cfg_data;
        met_pkg::REG_STEP_REAL:   step_real   <= cfg_data[30:0];
        met_pkg::REG_STEP_IMAG:   step_imag   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col <= col_next;
      row <= row_next;
    end
    if (cmd.coord_mul) begin
      cprod_real <= 43'(col) * 43'(step_real);
      cprod_imag <= 43'(row) * 43'(step_imag);
    end
    if (cmd.coord_add) begin
      cr <= met_pkg::sat32(64'(origin_real) + $signed(64'(cprod_real)));
      ci <= met_pkg::sat32(64'(origin_imag) + $signed(64'(cprod_imag)));
      u  <= '0;
      v  <= '0;
      n  <= '0;
    end
    if (cmd.iter_mul) begin
      uu <= uu_next;
      vv <= vv_next;
      uv <= uv_next;
    end
    if (cmd.iter_upd && status.cont) begin
      u <= met_pkg::sat32(nu_wide);
      v <= met_pkg::sat32(nv_wide);
      n <= n + 16'd1;
    end
    if (cmd.load_out) begin
      m_tdata <= n;
    end
  end

endmodule

@@ sv/mandelbrot_escape_time_top.sv @@
// Mandelbrot escape-time evaluator. Each input word carries one pixel position;
// the block forms c = (origin_real + col*step_real) + i*(origin_imag + row*step_imag)
// in signed Q4.28, saturating the coordinate, and iterates z = z*z + c from zero
// until |z|^2 reaches 4.0 or the count reaches the iteration limit, then returns the
// count as one output word. The coordinate is formed by loading the pixel, then
// multiplying and adding. Each escape test (n + 1 tests for a count of n)
// has one state that multiplies u*u, v*v and u*v in three 32 by 32 multipliers
// and a following state that tests for escape and saturates the new iterate.
// One pixel is worked on at a time; a finished count sits in the output
// register, and the next pixel is taken while it waits to be read. Column and
// row indices at or beyond MAX_COLUMNS or MAX_ROWS clamp to the last one.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user must
// write them only while the block is idle (unchecked by the block): 0 iteration limit,
// 1 origin_real, 2 origin_imag, 3 step_real, 4 step_imag; other indices are ignored.
`include "mandelbrot_escape_time_top_macros.svh"

module mandelbrot_escape_time_top #(
  parameter int unsigned MAX_COLUMNS = 4096,
  parameter int unsigned MAX_ROWS    = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [met_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // pixel_col [11:0], pixel_row [23:12]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata    // escape_count [15:0]
);

  met_pkg::met_cmd_t    cmd;
  met_pkg::met_status_t status;

  // The controller sequences coordinate setup and the iteration loop.
  met_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the registers, multipliers and the iteration counter.
  met_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

  // At most one datapath step is commanded in a cycle. The five step commands
  // sit above load_out in the command word.
  `MET_ASSERT_ALWAYS(a_one_step, $onehot0(cmd[5:1]), "more than one datapath step commanded")
  // A new count is never written over a word that is still unread.
  `MET_ASSERT_IMP(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready, "output word overwritten")
  // Once a pixel is taken, the block is busy in the next cycle.
  `MET_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")
  // The output only becomes valid after the controller loads a count.
  `MET_ASSERT_IMP(a_valid_source, $rose(m_tvalid), $past(cmd.load_out), "output valid without a load")

endmodule
